>>> sv/dfs_topological_sort_macros.svh
// ----------------------------------------------------------------------------
// dfs_topological_sort assertion macros
// Short forms for clocked implication checks, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef DFS_TOPOLOGICAL_SORT_MACROS_SVH
`define DFS_TOPOLOGICAL_SORT_MACROS_SVH

// Same-cycle implication on the rising edge of clk.
`define DFS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dfs_topological_sort: check failed");

// Next-cycle implication on the rising edge of clk.
`define DFS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dfs_topological_sort: check failed");

`endif

>>> sv/dfs_pkg.sv
// ----------------------------------------------------------------------------
// dfs_pkg
// Shared sizes, command codes and word types of the topological sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package dfs_pkg;

	localparam int NODE_SLOTS = 64;
	localparam int NODE_W     = 6;
	localparam int CNT_W      = 7;

	typedef enum logic [1:0] {
		FUNC_ADD_EDGE = 2'd0,
		FUNC_SORT     = 2'd1,
		FUNC_CLEAR    = 2'd2
	} func_t;

	typedef struct packed {
		logic [1:0]        func;
		logic [NODE_W-1:0] src_node;
		logic [NODE_W-1:0] dst_node;
	} cmd_t;

	typedef struct packed {
		logic [NODE_W-1:0] order_node;
		logic              last_of_order;
	} res_t;

endpackage

`default_nettype wire

>>> sv/dfs_topological_sort.sv
// ----------------------------------------------------------------------------
// dfs_topological_sort
// Adjacency-matrix graph store with a depth-first topological sorter.
// ----------------------------------------------------------------------------
// Usage:
//   A command word is taken on a rising edge with start high and busy low.
//   Add edge reads the source row and writes it back with the new bit set:
//   busy for one cycle, so the next word can follow once busy is low again.
//   Clear drops every edge in the cycle it is taken and never raises busy.
//   Sort runs a depth-first search over nodes below node_count (capped at 64),
//   roots in ascending order, then emits the reverse post-order: one result word
//   per node on consecutive cycles, each marked by result_valid for one
//   cycle, the final one with last_of_order set. The receiver cannot stall;
//   results simply stream out.
//   Sort search: one shared bit compare tests one neighbour per cycle while
//   scanning. For each node in use it scans every candidate neighbour and
//   then the end of the list; returning from each non-root node pops the
//   stack, and every root index is tested in turn. The result words follow
//   the search back to back, and busy drops as the final word goes out.
//   node_count is written through cfg_wdata with cfg_we; the user must do so
//   only while busy is low, as the block itself does not enforce it.
//   Reset leaves an empty graph (row valid flags cleared) and node_count 64.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_topological_sort (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire dfs_pkg::cmd_t           cmd,
	input  wire logic                    cfg_we,
	input  wire logic [dfs_pkg::CNT_W-1:0] cfg_wdata,
	output logic                         result_valid,
	output dfs_pkg::res_t                result
);
	import dfs_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_EDGE = 6'b000010,
		S_ROOT = 6'b000100,
		S_SCAN = 6'b001000,
		S_POP  = 6'b010000,
		S_EMIT = 6'b100000
	} state_t;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [CNT_W-1:0]  next;
	} stk_entry_t;

	state_t state_q;

	// configuration and sort bookkeeping
	logic [CNT_W-1:0]      node_cnt_q;
	logic [CNT_W-1:0]      n_q;
	logic [CNT_W-1:0]      root_q;
	logic [CNT_W-1:0]      depth_q;
	logic [CNT_W-1:0]      post_cnt_q;
	logic [NODE_W-1:0]     cur_v_q;
	logic [CNT_W-1:0]      cur_i_q;
	logic [NODE_W-1:0]     emit_idx_q;
	logic [NODE_SLOTS-1:0] visited_q;
	logic [NODE_SLOTS-1:0] row_vld_q;
	logic [NODE_W-1:0]     edge_src_q;
	logic [NODE_W-1:0]     edge_dst_q;

	// adjacency memory
	logic [NODE_SLOTS-1:0] adj_mem [NODE_SLOTS];
	logic [NODE_SLOTS-1:0] adj_rd_q;
	logic                  adj_vld_rd_q;
	logic                  adj_we, adj_re;
	logic [NODE_W-1:0]     adj_wa, adj_ra;
	logic [NODE_SLOTS-1:0] adj_wd;
	logic [NODE_SLOTS-1:0] row_eff;

	// search stack memory
	stk_entry_t        stk_mem [NODE_SLOTS];
	stk_entry_t        stk_rd_q;
	logic              stk_we, stk_re;
	logic [NODE_W-1:0] stk_wa, stk_ra;
	stk_entry_t        stk_wd;

	// post-order memory
	logic [NODE_W-1:0] po_mem [NODE_SLOTS];
	logic [NODE_W-1:0] po_rd_q;
	logic              po_we, po_re;
	logic [NODE_W-1:0] po_wa;

	logic res_vld_q, res_last_q;

	logic             accept;
	logic [CNT_W-1:0] depth_m1, depth_m2, post_m1, n_start;
	logic             cand_end, cand_hit, root_end, root_vis;

	assign accept   = start && (state_q == S_IDLE);
	assign busy     = (state_q != S_IDLE);
	assign row_eff  = adj_vld_rd_q ? adj_rd_q : '0;
	assign depth_m1 = depth_q - CNT_W'(1);
	assign depth_m2 = depth_q - CNT_W'(2);
	assign post_m1  = post_cnt_q - CNT_W'(1);
	assign n_start  = (node_cnt_q > CNT_W'(NODE_SLOTS)) ? CNT_W'(NODE_SLOTS) : node_cnt_q;

	// the shared compare: one neighbour of the top-of-stack node per cycle while scanning
	assign cand_end = (cur_i_q >= n_q);
	assign cand_hit = !cand_end && row_eff[cur_i_q[NODE_W-1:0]]
		&& !visited_q[cur_i_q[NODE_W-1:0]];
	assign root_end = (root_q >= n_q);
	assign root_vis = visited_q[root_q[NODE_W-1:0]];

	// memory port steering
	always_comb begin
		adj_we = 1'b0;
		adj_wa = edge_src_q;
		adj_wd = row_eff | (NODE_SLOTS'(1) << edge_dst_q);
		adj_re = 1'b0;
		adj_ra = cmd.src_node;
		stk_we = 1'b0;
		stk_wa = depth_m1[NODE_W-1:0];
		stk_wd = '{node: cur_v_q, next: cur_i_q + CNT_W'(1)};
		stk_re = 1'b0;
		stk_ra = depth_m2[NODE_W-1:0];
		po_we  = 1'b0;
		po_wa  = post_cnt_q[NODE_W-1:0];
		po_re  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				adj_re = accept && (cmd.func == FUNC_ADD_EDGE);
			end
			S_EDGE: begin
				adj_we = 1'b1;
			end
			S_ROOT: begin
				adj_ra = root_q[NODE_W-1:0];
				adj_re = !root_end && !root_vis;
			end
			S_SCAN: begin
				if (cand_hit) begin
					// push: remember where to resume, descend into the neighbour
					stk_we = 1'b1;
					adj_re = 1'b1;
					adj_ra = cur_i_q[NODE_W-1:0];
				end else if (cand_end) begin
					po_we  = 1'b1;
					stk_re = (depth_q > CNT_W'(1));
				end
			end
			S_POP: begin
				adj_re = 1'b1;
				adj_ra = stk_rd_q.node;
			end
			S_EMIT: begin
				po_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adj_we) adj_mem[adj_wa] <= adj_wd;
		if (adj_re) adj_rd_q <= adj_mem[adj_ra];
		if (stk_we) stk_mem[stk_wa] <= stk_wd;
		if (stk_re) stk_rd_q <= stk_mem[stk_ra];
		if (po_we)  po_mem[po_wa] <= cur_v_q;
		if (po_re)  po_rd_q <= po_mem[emit_idx_q];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			node_cnt_q   <= CNT_W'(NODE_SLOTS);
			n_q          <= '0;
			root_q       <= '0;
			depth_q      <= '0;
			post_cnt_q   <= '0;
			cur_v_q      <= '0;
			cur_i_q      <= '0;
			emit_idx_q   <= '0;
			visited_q    <= '0;
			row_vld_q    <= '0;
			adj_vld_rd_q <= 1'b0;
			edge_src_q   <= '0;
			edge_dst_q   <= '0;
			res_vld_q    <= 1'b0;
			res_last_q   <= 1'b0;
		end else begin
			if (cfg_we) node_cnt_q <= cfg_wdata;
			if (adj_re) adj_vld_rd_q <= row_vld_q[adj_ra];
			res_vld_q  <= (state_q == S_EMIT);
			res_last_q <= (emit_idx_q == '0);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd.func)
							FUNC_ADD_EDGE: begin
								edge_src_q <= cmd.src_node;
								edge_dst_q <= cmd.dst_node;
								state_q    <= S_EDGE;
							end
							FUNC_SORT: begin
								visited_q  <= '0;
								post_cnt_q <= '0;
								root_q     <= '0;
								n_q        <= n_start;
								// an empty node set yields nothing: stay idle
								if (n_start != '0) state_q <= S_ROOT;
							end
							FUNC_CLEAR: begin
								row_vld_q <= '0;
								visited_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_EDGE: begin
					row_vld_q[edge_src_q] <= 1'b1;
					state_q <= S_IDLE;
				end
				S_ROOT: begin
					if (root_end) begin
						emit_idx_q <= post_m1[NODE_W-1:0];
						state_q    <= S_EMIT;
					end else if (root_vis) begin
						root_q <= root_q + CNT_W'(1);
					end else begin
						visited_q[root_q[NODE_W-1:0]] <= 1'b1;
						cur_v_q <= root_q[NODE_W-1:0];
						cur_i_q <= '0;
						depth_q <= CNT_W'(1);
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (cand_hit) begin
						visited_q[cur_i_q[NODE_W-1:0]] <= 1'b1;
						cur_v_q <= cur_i_q[NODE_W-1:0];
						cur_i_q <= '0;
						depth_q <= depth_q + CNT_W'(1);
					end else if (cand_end) begin
						// node finished: record it and drop it from the stack
						post_cnt_q <= post_cnt_q + CNT_W'(1);
						depth_q    <= depth_m1;
						if (depth_q > CNT_W'(1)) begin
							state_q <= S_POP;
						end else begin
							root_q  <= root_q + CNT_W'(1);
							state_q <= S_ROOT;
						end
					end else begin
						cur_i_q <= cur_i_q + CNT_W'(1);
					end
				end
				S_POP: begin
					cur_v_q <= stk_rd_q.node;
					cur_i_q <= stk_rd_q.next;
					state_q <= S_SCAN;
				end
				S_EMIT: begin
					if (emit_idx_q == '0) begin
						state_q <= S_IDLE;
					end else begin
						emit_idx_q <= emit_idx_q - NODE_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = res_vld_q;
	assign result       = '{order_node: po_rd_q, last_of_order: res_last_q};

endmodule

`default_nettype wire

>>> sv/dfs_checker.sv
// ----------------------------------------------------------------------------
// dfs_checker
// Port-level checks of the topological sorter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dfs_topological_sort_macros.svh"

module dfs_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       start,
	input wire logic                       busy,
	input wire dfs_pkg::cmd_t              cmd,
	input wire logic                       result_valid,
	input wire dfs_pkg::res_t              result
);
	import dfs_pkg::*;

	logic taken_other;

	assign taken_other = start && !busy && (cmd.func != FUNC_SORT);

	// results only stream out of a running sort
	`DFS_ASSERT_SAME(a_result_in_sort, result_valid, $past(busy))
	// edge or clear words never produce a result
	`DFS_ASSERT_NEXT(a_no_result_other, taken_other, !result_valid)
	// the final word closes the stream
	`DFS_ASSERT_NEXT(a_last_ends, result_valid && result.last_of_order, !result_valid)
	// words before the final one follow back to back
	`DFS_ASSERT_NEXT(a_stream_gapless, result_valid && !result.last_of_order, result_valid)

endmodule

bind dfs_topological_sort dfs_checker u_dfs_checker (.*);

`default_nettype wire
